[design/int8_query_key_dot_requant_assert.svh]
// ----------------------------------------------------------------------------
// int8_query_key_dot_requant assertion macros
// Shared property forms for the score unit checks.
// ----------------------------------------------------------------------------
`ifndef INT8_QUERY_KEY_DOT_REQUANT_ASSERT_SVH
`define INT8_QUERY_KEY_DOT_REQUANT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KQD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kqd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kqd: next-cycle check failed");

`endif

[design/kqd_pkg.sv]
// ----------------------------------------------------------------------------
// kqd_pkg
// Types, register codes and constants of the int8 query-key score unit.
// ----------------------------------------------------------------------------
package kqd_pkg;

	// item action codes
	localparam logic ACT_KEY_LOAD = 1'b0;
	localparam logic ACT_QUERY    = 1'b1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_USED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_MULT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_SHIFT  = 2'd3;

	localparam logic [4:0]         KEY_COUNT_RST  = 5'd16;
	localparam logic [8:0]         DEPTH_USED_RST = 9'd130;
	localparam logic signed [31:0] REQ_MULT_RST   = 32'sd1;
	localparam logic [5:0]         REQ_SHIFT_RST  = 6'd0;

	// reach of the key_row and depth_index fields
	localparam int FIELD_KEYS  = 16;
	localparam int FIELD_DEPTH = 256;

	// int8 saturation bounds
	localparam logic signed [7:0] SCORE_MAX = 8'sd127;
	localparam logic signed [7:0] SCORE_MIN = -8'sd128;

	typedef struct packed {
		logic              action;
		logic [3:0]        query_row;
		logic [3:0]        key_row;
		logic [7:0]        depth_index;
		logic signed [7:0] value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]        row;
		logic [3:0]        column;
		logic signed [7:0] score;
		logic              last;
	} out_item_t;

	// one accumulator read handed to the requantizer
	typedef struct packed {
		logic       valid;
		logic [3:0] row;
		logic [3:0] column;
		logic       last;
		logic       acc_vld;
	} rq_issue_t;

	// requantizer status back to the sequencer
	typedef struct packed {
		logic adv;
		logic s1_busy;
	} rq_status_t;

endpackage

[design/int8_query_key_dot_requant.sv]
// Key load: each item is written straight into the key store as it is taken. Query byte: the
// single read port of the accumulator RAM reads one key row per cycle, then a drain state lets
// the last write-back land, and no item is taken meanwhile. A row-closing byte then issues one
// accumulator read per active key, one per cycle unless the output stalls, to the requantizer.
// Reset clears control state and the accumulator valid bits and loads the register defaults;
// the key store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// int8_query_key_dot_requant
// int8 attention score unit: accumulate Q x K^T per query row out of a key
// store, then requantize and saturate one score per active key.
// ----------------------------------------------------------------------------
`include "int8_query_key_dot_requant_assert.svh"

module int8_query_key_dot_requant import kqd_pkg::*; #(
	parameter int MAX_KEYS  = 16,
	parameter int MAX_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// item input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	// score output
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	// Keys and depth in use are bounded by the parameters and by the field reach.
	localparam int NKEY   = (MAX_KEYS < FIELD_KEYS) ? MAX_KEYS : FIELD_KEYS;
	localparam int NDEP   = (MAX_DEPTH < FIELD_DEPTH) ? MAX_DEPTH : FIELD_DEPTH;
	localparam int KW     = (NKEY > 1) ? $clog2(NKEY) : 1;
	localparam int KSTORE = MAX_KEYS * MAX_DEPTH;
	localparam int KAW    = $clog2(KSTORE);

	localparam logic [4:0] NKEY_C = 5'(NKEY);
	localparam logic [8:0] NDEP_C = 9'(NDEP);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_SCORE = 2'd3;

	// configuration registers
	logic [4:0]         key_count_q;
	logic [8:0]         depth_used_q;
	logic signed [31:0] req_mult_q;
	logic [5:0]         req_shift_q;

	// sequencer
	logic [1:0]        state_q;
	logic [KW-1:0]     j_q;
	logic [KAW-1:0]    kaddr_q;
	logic [4:0]        kc_last_q;
	logic [3:0]        qrow_q;
	logic signed [7:0] qval_q;
	logic              close_q;
	logic [NKEY-1:0]   acc_vld_q;

	// MAC write-back stage
	logic          mac_v_s1;
	logic [KW-1:0] mac_j_s1;
	logic          mac_vld_s1;

	logic [4:0] kc;
	logic [8:0] dd;
	logic [8:0] dd_last;

	logic in_acc;
	logic key_we;
	logic q_go;
	logic mac_issue;
	logic score_issue;
	logic issue_last;

	logic [KAW-1:0] key_waddr;
	logic [7:0]     key_rdata;
	logic [31:0]    acc_rdata;
	logic [31:0]    acc_wdata;
	logic           acc_re;

	logic signed [7:0]  kbyte;
	logic signed [15:0] mac_prod;
	logic [31:0]        acc_old;

	rq_issue_t  rq_issue;
	rq_status_t rq_st;

	// ------------------------------------------------------------------
	// Configuration: registers hold the raw written bits; clamp on use.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= KEY_COUNT_RST;
			depth_used_q <= DEPTH_USED_RST;
			req_mult_q   <= REQ_MULT_RST;
			req_shift_q  <= REQ_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_COUNT:  key_count_q  <= cfg_data[4:0];
				CFG_DEPTH_USED: depth_used_q <= cfg_data[8:0];
				CFG_REQ_MULT:   req_mult_q   <= signed'(cfg_data[31:0]);
				CFG_REQ_SHIFT:  req_shift_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Effective key count and depth: zero acts as one, large values saturate.
	always_comb begin
		kc = key_count_q;
		if (kc == 5'd0) kc = 5'd1;
		if (kc > NKEY_C) kc = NKEY_C;
		dd = depth_used_q;
		if (dd == 9'd0) dd = 9'd1;
		if (dd > NDEP_C) dd = NDEP_C;
		dd_last = dd - 9'd1;
	end

	// ------------------------------------------------------------------
	// Input transfer. Items are taken only in IDLE, and only once the
	// requantizer no longer needs the accumulator RAM read data.
	// ------------------------------------------------------------------
	assign in_stall = (state_q != ST_IDLE) || rq_st.s1_busy;
	assign in_acc   = in_valid && !in_stall;

	// Key load: write straight into the key store; out-of-range loads drop.
	assign key_we = in_acc && (in_data.action == ACT_KEY_LOAD)
		&& (32'(in_data.key_row) < MAX_KEYS) && (32'(in_data.depth_index) < MAX_DEPTH);
	assign key_waddr = KAW'(32'(in_data.key_row) * MAX_DEPTH + 32'(in_data.depth_index));

	// Query byte: bytes beyond the active depth drop without effect.
	assign q_go = in_acc && (in_data.action == ACT_QUERY)
		&& ({1'b0, in_data.depth_index} < dd);

	assign mac_issue   = (state_q == ST_MAC);
	assign score_issue = (state_q == ST_SCORE) && rq_st.adv;
	assign issue_last  = (5'(j_q) == kc_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_go) state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (issue_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// let the last write-back land before any score read
					state_q <= close_q ? ST_SCORE : ST_IDLE;
				end
				ST_SCORE: begin
					if (score_issue && issue_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sequencer payload: key row walk and per-row capture.
	always_ff @(posedge clk) begin
		if (q_go) begin
			j_q       <= '0;
			kaddr_q   <= KAW'(in_data.depth_index);
			kc_last_q <= kc - 5'd1;
			qrow_q    <= in_data.query_row;
			qval_q    <= in_data.value;
			close_q   <= ({1'b0, in_data.depth_index} == dd_last);
		end else if (mac_issue) begin
			// advance one key row: same depth, next row of the store
			j_q     <= j_q + KW'(1);
			kaddr_q <= kaddr_q + KAW'(MAX_DEPTH);
		end else if (state_q == ST_DRAIN) begin
			j_q <= '0;
		end else if (score_issue) begin
			j_q <= j_q + KW'(1);
		end
	end

	// ------------------------------------------------------------------
	// MAC: read key byte and accumulator, add the product, write back.
	// Entries of one byte are distinct, and the drain state separates
	// the last write-back from the score reads.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
		end else begin
			mac_v_s1 <= mac_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_issue) begin
			mac_j_s1   <= j_q;
			mac_vld_s1 <= acc_vld_q[j_q];
		end
	end

	assign kbyte     = signed'(key_rdata);
	assign mac_prod  = qval_q * kbyte;
	assign acc_old   = mac_vld_s1 ? acc_rdata : 32'd0;
	assign acc_wdata = acc_old + unsigned'(32'(mac_prod));

	// Valid bits stand in for the all-zero reset and the clear after each row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (score_issue && issue_last) begin
			acc_vld_q <= '0;
		end else if (mac_v_s1) begin
			acc_vld_q[mac_j_s1] <= 1'b1;
		end
	end

	assign acc_re = mac_issue || score_issue;

	kqd_ram #(
		.WIDTH(8),
		.DEPTH(KSTORE)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(in_data.value),
		.re   (mac_issue),
		.raddr(kaddr_q),
		.rdata(key_rdata)
	);

	kqd_ram #(
		.WIDTH(32),
		.DEPTH(NKEY)
	) u_acc_ram (
		.clk  (clk),
		.we   (mac_v_s1),
		.waddr(mac_j_s1),
		.wdata(acc_wdata),
		.re   (acc_re),
		.raddr(j_q),
		.rdata(acc_rdata)
	);

	// ------------------------------------------------------------------
	// Scoring: one accumulator read per cycle into the requantizer while it can advance.
	// ------------------------------------------------------------------
	assign rq_issue.valid   = score_issue;
	assign rq_issue.row     = qrow_q;
	assign rq_issue.column  = 4'(j_q);
	assign rq_issue.last    = issue_last;
	assign rq_issue.acc_vld = acc_vld_q[j_q];

	kqd_requant u_requant (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_mult  (req_mult_q),
		.req_shift (req_shift_q),
		.issue     (rq_issue),
		.acc_rdata (acc_rdata),
		.status    (rq_st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// closing a row leaves every accumulator reading as zero
	`KQD_ASSERT_NEXT(a_row_clears_acc, clk, arst_n, score_issue && issue_last, acc_vld_q == '0)
	// the key row walk never passes the active key count
	`KQD_ASSERT_SAME(a_mac_in_range, clk, arst_n, mac_issue, 5'(j_q) <= kc_last_q)
	// MAC write-back and score reads never share the accumulator RAM
	`KQD_ASSERT_SAME(a_acc_port_excl, clk, arst_n, mac_v_s1, state_q != ST_SCORE)

endmodule

[design/kqd_ram.sv]
// ----------------------------------------------------------------------------
// kqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/kqd_requant.sv]
// ----------------------------------------------------------------------------
// kqd_requant
// Requantize pipeline: multiply, magnitude, round-shift, saturate, output reg.
// ----------------------------------------------------------------------------
module kqd_requant import kqd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] req_mult,
	input  logic [5:0]         req_shift,
	input  rq_issue_t          issue,
	input  logic [31:0]        acc_rdata,
	output rq_status_t         status,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	localparam logic [63:0] POS_LIM = 64'(SCORE_MAX);
	localparam int          NEG_MAG = -int'(SCORE_MIN);
	localparam logic [63:0] NEG_LIM = 64'(NEG_MAG);

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic [3:0] row_s1, row_s2, row_s3, row_s4;
	logic [3:0] col_s1, col_s2, col_s3, col_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic vld_s1;

	logic signed [31:0] acc_s;
	logic signed [63:0] prod_s2;
	logic [63:0]        mag_s3;
	logic               neg_s3, neg_s4;
	logic [63:0]        q_s4;

	logic [63:0]       half;
	logic [63:0]       rnd;
	logic signed [7:0] score_d;
	out_item_t         out_q;

	// the whole pipeline moves only when the output register can take a value
	assign adv = !out_valid_q || !out_stall;

	// never-written accumulators read as zero
	assign acc_s = vld_s1 ? signed'(acc_rdata) : 32'sd0;

	always_comb begin
		half = (req_shift == 6'd0) ? 64'd0 : (64'd1 << (req_shift - 6'd1));
		rnd  = (mag_s3 + half) >> req_shift;
	end

	always_comb begin
		if (neg_s4) begin
			score_d = (q_s4 > NEG_LIM) ? SCORE_MIN : signed'(8'd0 - q_s4[7:0]);
		end else begin
			score_d = (q_s4 > POS_LIM) ? SCORE_MAX : signed'(q_s4[7:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1  <= issue.row;
			col_s1  <= issue.column;
			last_s1 <= issue.last;
			vld_s1  <= issue.acc_vld;

			prod_s2 <= acc_s * req_mult;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;

			neg_s3  <= prod_s2[63];
			mag_s3  <= prod_s2[63] ? (64'd0 - unsigned'(prod_s2)) : unsigned'(prod_s2);
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			last_s3 <= last_s2;

			neg_s4  <= neg_s3;
			q_s4    <= rnd;
			row_s4  <= row_s3;
			col_s4  <= col_s3;
			last_s4 <= last_s3;

			if (v_s4) begin
				out_q.row    <= row_s4;
				out_q.column <= col_s4;
				out_q.score  <= score_d;
				out_q.last   <= last_s4;
			end
		end
	end

	assign status.adv     = adv;
	assign status.s1_busy = v_s1;
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

endmodule

[test/tb_int8_query_key_dot_requant.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int8_query_key_dot_requant
// Self-checking bench for the int8 query-key score unit. Key bytes are
// loaded into the key store, query rows are streamed through it, and every
// score transfer is compared field by field against an in-bench model of
// the accumulate, requantize and saturate path.
// ----------------------------------------------------------------------------
module tb_int8_query_key_dot_requant;
	import kqd_pkg::*;

	localparam int KEYS          = 16;
	localparam int DEPTH         = 256;
	localparam int IN_W          = $bits(in_item_t);
	localparam int ITEMS         = 170;   // random transfers to aim for
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
	localparam int SETTLE_CYCLES = 64;    // covers a non-closing query byte in flight

	// one line of the directed plan: either a register setting or an item
	typedef struct {
		bit                is_cfg;
		logic [4:0]        kc;
		logic [8:0]        dep;
		logic [31:0]       mult;
		logic [5:0]        sh;
		in_item_t          it;
		bit                typed;   // scores below are hand-derived
		logic signed [7:0] s0;
		logic signed [7:0] s1;
	} plan_step_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	// bench copy of the block's state
	logic signed [7:0] key_mem [KEYS][DEPTH];
	bit                key_written [KEYS][DEPTH];
	logic [31:0]       dot_acc [KEYS];
	logic [4:0]        cfg_keys  = KEY_COUNT_RST;
	logic [8:0]        cfg_depth = DEPTH_USED_RST;
	logic [31:0]       cfg_mult  = REQ_MULT_RST;
	logic [5:0]        cfg_shift = REQ_SHIFT_RST;

	out_item_t   pending_scores [$];
	out_item_t   want;
	int          mismatches = 0;
	int          sent       = 0;
	int unsigned send_idle  = 0;
	int unsigned stall_pct  = 0;
	bit          hold_tog   = 1'b0;
	bit          hold_seen  = 1'b0;
	int unsigned hold_left  = 0;

	plan_step_t directed [$];

	int8_query_key_dot_requant #(
		.MAX_KEYS  (KEYS),
		.MAX_DEPTH (DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Score model
	// ------------------------------------------------------------------

	// out-of-range register values clamp to the usable span
	function automatic int unsigned eff_keys();
		if (cfg_keys == 0) return 1;
		if (32'(cfg_keys) > KEYS) return KEYS;
		return 32'(cfg_keys);
	endfunction

	function automatic int unsigned eff_depth();
		if (cfg_depth == 0) return 1;
		if (32'(cfg_depth) > DEPTH) return DEPTH;
		return 32'(cfg_depth);
	endfunction

	// 64-bit multiply, shift with rounding half away from zero, clamp to int8
	function automatic logic signed [7:0] requant_score(input logic [31:0] acc);
		logic signed [63:0] prod;
		logic [63:0]        mag;
		logic [63:0]        half;
		logic [63:0]        q;
		prod = $signed({{32{acc[31]}}, acc}) * $signed({{32{cfg_mult[31]}}, cfg_mult});
		mag  = prod[63] ? 64'(-prod) : 64'(prod);
		half = (cfg_shift == 0) ? 64'd0 : (64'd1 << (cfg_shift - 6'd1));
		q    = (mag + half) >> cfg_shift;
		if (prod[63]) begin
			if (q > 64'd128) q = 64'd128;
			return 8'(-q);
		end
		if (q > 64'd127) q = 64'd127;
		return 8'(q);
	endfunction

	// Update the model with one accepted item and queue the scores it closes.
	// A typed row supplies its scores by hand; row, column and last still
	// follow from the item and the active key count.
	task automatic predict_scores(input in_item_t it, input bit typed,
			input logic signed [7:0] t0, input logic signed [7:0] t1);
		int unsigned        nk;
		int unsigned        nd;
		logic signed [31:0] prod;
		out_item_t          r;
		if (it.action == ACT_KEY_LOAD) begin
			key_mem[it.key_row][it.depth_index]     = it.value;
			key_written[it.key_row][it.depth_index] = 1'b1;
			return;
		end
		nd = eff_depth();
		if (32'(it.depth_index) >= nd) return;   // beyond the row: drop
		nk = eff_keys();
		for (int j = 0; j < nk; j++) begin
			prod = $signed(it.value) * key_mem[j][it.depth_index];
			dot_acc[j] += prod;
		end
		if (32'(it.depth_index) != nd - 1) return;
		for (int j = 0; j < nk; j++) begin
			r.row    = it.query_row;
			r.column = 4'(j);
			r.score  = typed ? ((j == 0) ? t0 : t1) : requant_score(dot_acc[j]);
			r.last   = (j == nk - 1);
			pending_scores.push_back(r);
		end
		for (int j = 0; j < KEYS; j++) dot_acc[j] = '0;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic in_item_t mk_item(input logic act, input logic [3:0] qr,
			input logic [3:0] kr, input logic [7:0] d, input logic signed [7:0] v);
		in_item_t it;
		it.action      = act;
		it.query_row   = qr;
		it.key_row     = kr;
		it.depth_index = d;
		it.value       = v;
		return it;
	endfunction

	function automatic plan_step_t cfg_step(input logic [4:0] kc, input logic [8:0] dep,
			input logic [31:0] mult, input logic [5:0] sh);
		plan_step_t s;
		s        = '{default: '0};
		s.is_cfg = 1'b1;
		s.kc     = kc;
		s.dep    = dep;
		s.mult   = mult;
		s.sh     = sh;
		return s;
	endfunction

	function automatic plan_step_t load_step(input logic [3:0] kr, input logic [7:0] d,
			input logic signed [7:0] v);
		plan_step_t s;
		s    = '{default: '0};
		s.it = mk_item(ACT_KEY_LOAD, 4'd0, kr, d, v);
		return s;
	endfunction

	function automatic plan_step_t query_step(input logic [3:0] qr, input logic [7:0] d,
			input logic signed [7:0] v, input bit typed,
			input logic signed [7:0] s0, input logic signed [7:0] s1);
		plan_step_t s;
		s       = '{default: '0};
		s.it    = mk_item(ACT_QUERY, qr, 4'd0, d, v);
		s.typed = typed;
		s.s0    = s0;
		s.s1    = s1;
		return s;
	endfunction

	// int8 value with the extremes weighted up
	function automatic logic signed [7:0] rnd_byte();
		case ($urandom_range(7))
			0: return SCORE_MAX;
			1: return SCORE_MIN;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one item after an optional idle gap and hold it until the transfer.
	// Handshake signals are read at the edge, before the block updates them.
	task automatic send(input in_item_t it, input bit typed,
			input logic signed [7:0] t0, input logic signed [7:0] t1);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			in_data  <= in_item_t'(IN_W'($urandom));   // junk while idle
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		predict_scores(it, typed, t0, t1);
		sent++;
	endtask

	// Drop valid and wait until every queued score is out and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers on back-to-back edges; the block must be idle.
	task automatic configure(input logic [4:0] kc, input logic [8:0] dep,
			input logic [31:0] mult, input logic [5:0] sh);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEY_COUNT;
		cfg_data  <= 32'(kc);
		@(posedge clk);
		cfg_index <= CFG_DEPTH_USED;
		cfg_data  <= 32'(dep);
		@(posedge clk);
		cfg_index <= CFG_REQ_MULT;
		cfg_data  <= mult;
		@(posedge clk);
		cfg_index <= CFG_REQ_SHIFT;
		cfg_data  <= 32'(sh);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_keys  = kc;
		cfg_depth = dep;
		cfg_mult  = mult;
		cfg_shift = sh;
	endtask

	// One stray item: a key rewrite anywhere, a query past the row end,
	// or a query byte at a depth whose keys are loaded.
	task automatic stray_item(input logic [3:0] qr, input int unsigned nd,
			input int unsigned ready[$]);
		case ($urandom_range(2))
			0: send(mk_item(ACT_KEY_LOAD, qr, 4'($urandom), 8'($urandom), rnd_byte()),
					1'b0, 8'sd0, 8'sd0);
			1: if (nd < DEPTH)
				send(mk_item(ACT_QUERY, qr, 4'($urandom), 8'($urandom_range(nd, DEPTH - 1)),
						rnd_byte()), 1'b0, 8'sd0, 8'sd0);
			default: send(mk_item(ACT_QUERY, qr, 4'($urandom),
					8'(ready[$urandom_range(0, ready.size() - 1)]), rnd_byte()),
					1'b0, 8'sd0, 8'sd0);
		endcase
	endtask

	// One random phase: pick an idle pattern and a register setting, load any
	// key bytes the rows will need, then stream mostly complete query rows
	// mixed with broken rows and stray items.
	task automatic run_phase(input int p);
		logic [4:0]  kc;
		logic [8:0]  dep;
		logic [31:0] mult;
		logic [5:0]  sh;
		logic [3:0]  qr;
		int unsigned nk;
		int unsigned nd;
		int unsigned nrows;
		int unsigned plan_d[$];
		int unsigned ready[$];
		bit          ok;

		settle();
		case (p % 4)
			0: begin send_idle = 0;  stall_pct = 0;  end
			1: begin send_idle = 58; stall_pct = 0;  end
			2: begin send_idle = 0;  stall_pct = 58; end
			default: begin send_idle = 18; stall_pct = 18; end
		endcase

		case ($urandom_range(9))
			0: kc = 5'd0;
			1: kc = 5'($urandom_range(17, 31));
			2: kc = 5'd16;
			default: kc = 5'($urandom_range(1, 15));
		endcase
		dep = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(1, 5));
		// fill the block in phase 0, saturate the key count in phase 1,
		// and take the longest rows in phases 2 and 3 with few keys
		if (p == 0) kc = 5'd16;
		if (p == 1) kc = 5'd31;
		if (p == 2 || p == 3) begin
			kc  = 5'($urandom_range(0, 3));
			dep = (p == 2) ? 9'd256 : 9'd511;
		end

		case ($urandom_range(5))
			0: begin mult = 32'd1; sh = 6'd0; end
			1: begin mult = 32'($signed($urandom_range(0, 1023)) - 512); sh = 6'($urandom_range(0, 14)); end
			2: begin mult = $urandom; sh = 6'($urandom_range(24, 48)); end
			3: begin
				mult = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
				sh   = 6'($urandom_range(20, 63));
			end
			4: begin mult = 32'($urandom_range(0, 255)); sh = $urandom_range(1) ? 6'd62 : 6'd63; end
			default: begin mult = 32'd0; sh = 6'($urandom_range(0, 63)); end
		endcase
		configure(kc, dep, mult, sh);

		nk = eff_keys();
		nd = eff_depth();
		// short rows load every depth, long rows only a sparse set
		if (nd <= 16) begin
			for (int d = 0; d < nd; d++) plan_d.push_back(d);
		end else begin
			plan_d.push_back(0);
			repeat (6) plan_d.push_back($urandom_range(1, nd - 2));
			plan_d.push_back(nd - 1);
		end
		foreach (plan_d[i])
			for (int j = 0; j < nk; j++)
				if (!key_written[j][plan_d[i]] || $urandom_range(7) == 0)
					send(mk_item(ACT_KEY_LOAD, 4'($urandom), 4'(j), 8'(plan_d[i]), rnd_byte()),
							1'b0, 8'sd0, 8'sd0);

		// a query byte may only touch depths loaded for every active key
		for (int d = 0; d < nd; d++) begin
			ok = 1'b1;
			for (int j = 0; j < nk; j++) ok &= key_written[j][d];
			if (ok) ready.push_back(d);
		end

		nrows = (p == 0) ? 8 : $urandom_range(2, 5);
		if (p == 0) hold_tog <= ~hold_tog;   // start the long receiver hold-off

		repeat (nrows) begin
			qr = 4'($urandom);
			case ($urandom_range(9))
				7: begin
					// broken row: a few bytes, closed only sometimes
					repeat ($urandom_range(0, 3))
						send(mk_item(ACT_QUERY, qr, 4'($urandom),
								8'(ready[$urandom_range(0, ready.size() - 1)]), rnd_byte()),
								1'b0, 8'sd0, 8'sd0);
					if ($urandom_range(1))
						send(mk_item(ACT_QUERY, qr, 4'($urandom), 8'(nd - 1), rnd_byte()),
								1'b0, 8'sd0, 8'sd0);
				end
				8, 9: repeat (3) stray_item(qr, nd, ready);
				default: begin
					// well-formed row in depth order, closing byte last
					foreach (ready[i])
						if (ready[i] != nd - 1) begin
							if ($urandom_range(9) == 0) stray_item(qr, nd, ready);
							send(mk_item(ACT_QUERY, qr, 4'($urandom), 8'(ready[i]), rnd_byte()),
									1'b0, 8'sd0, 8'sd0);
						end
					send(mk_item(ACT_QUERY, qr, 4'($urandom), 8'(nd - 1), rnd_byte()),
							1'b0, 8'sd0, 8'sd0);
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall, or a long hold-off when the toggle flips
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Score checker: each transfer against the oldest pending score
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				$error("unexpected score transfer: row %0d column %0d score %0d",
						out_data.row, out_data.column, $signed(out_data.score));
				mismatches++;
			end else begin
				want = pending_scores.pop_front();
				if (out_data.row !== want.row) begin
					$error("row: expected %0d, actual %0d", want.row, out_data.row);
					mismatches++;
				end
				if (out_data.column !== want.column) begin
					$error("column: expected %0d, actual %0d", want.column, out_data.column);
					mismatches++;
				end
				if (out_data.score !== want.score) begin
					$error("score: expected %0d, actual %0d",
							$signed(want.score), $signed(out_data.score));
					mismatches++;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, out_data.last);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int p;
		for (int j = 0; j < KEYS; j++) begin
			dot_acc[j] = '0;
			for (int d = 0; d < DEPTH; d++) begin
				key_mem[j][d]     = '0;
				key_written[j][d] = 1'b0;
			end
		end

		// Directed plan. Two keys of length two hold +127 and -128 so that
		// the saturated scores can be read off directly; then a key count
		// and depth of zero, the half-way rounding case, the multiplier
		// extremes and the largest shift.
		directed = '{
			cfg_step(5'd2, 9'd2, 32'd1, 6'd0),
			load_step(4'd0, 8'd0, SCORE_MAX),
			load_step(4'd0, 8'd1, SCORE_MAX),
			load_step(4'd1, 8'd0, SCORE_MIN),
			load_step(4'd1, 8'd1, SCORE_MIN),
			query_step(4'd5,  8'd0,   SCORE_MAX, 1'b0, 8'sd0, 8'sd0),
			query_step(4'd5,  8'd1,   SCORE_MAX, 1'b1, SCORE_MAX, SCORE_MIN),
			query_step(4'd15, 8'd0,   SCORE_MIN, 1'b0, 8'sd0, 8'sd0),
			query_step(4'd15, 8'd1,   SCORE_MIN, 1'b1, SCORE_MIN, SCORE_MAX),
			query_step(4'd3,  8'd2,   -8'sd1,    1'b0, 8'sd0, 8'sd0),   // past the row end
			query_step(4'd3,  8'd255, -8'sd1,    1'b0, 8'sd0, 8'sd0),
			query_step(4'd0,  8'd1,   8'sd1,     1'b1, SCORE_MAX, SCORE_MIN),  // close alone
			query_step(4'd1,  8'd0,   8'sd0,     1'b0, 8'sd0, 8'sd0),
			query_step(4'd1,  8'd1,   8'sd0,     1'b1, 8'sd0, 8'sd0),
			cfg_step(5'd0, 9'd0, 32'd1, 6'd1),
			query_step(4'd2,  8'd0,   8'sd1,     1'b1, 8'sd64, 8'sd0),   // 63.5 rounds up
			query_step(4'd3,  8'd0,   -8'sd1,    1'b1, -8'sd64, 8'sd0),
			query_step(4'd4,  8'd1,   8'sd5,     1'b0, 8'sd0, 8'sd0),
			cfg_step(5'd1, 9'd1, 32'h8000_0000, 6'd0),
			query_step(4'd6,  8'd0,   8'sd1,     1'b1, SCORE_MIN, 8'sd0),
			query_step(4'd7,  8'd0,   SCORE_MIN, 1'b1, SCORE_MAX, 8'sd0),
			cfg_step(5'd1, 9'd1, 32'h7fff_ffff, 6'd63),
			query_step(4'd8,  8'd0,   SCORE_MIN, 1'b1, 8'sd0, 8'sd0),
			query_step(4'd9,  8'd0,   SCORE_MAX, 1'b1, 8'sd0, 8'sd0)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				settle();
				configure(directed[i].kc, directed[i].dep, directed[i].mult, directed[i].sh);
			end else begin
				send(directed[i].it, directed[i].typed, directed[i].s0, directed[i].s1);
			end
		end

		sent = 0;
		p    = 0;
		while (sent < ITEMS || p < 4) begin
			run_phase(p);
			p++;
		end

		settle();
		if (mismatches == 0 && pending_scores.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// hang guard: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/kqd_pkg.sv
design/kqd_ram.sv
design/kqd_requant.sv
design/int8_query_key_dot_requant.sv
test/tb_int8_query_key_dot_requant.sv
